// ===== rtl/core/hue_class_minmax_tracker_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Hue class min/max tracker: assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef HUE_CLASS_MINMAX_TRACKER_UNIT_MACROS_SVH
`define HUE_CLASS_MINMAX_TRACKER_UNIT_MACROS_SVH

// Checked only outside reset.
`define HCMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define HCMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hcmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Hue class min/max tracker package
// Class codes, hue ranges, bound record type and the class lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package hcmt_pkg;

  localparam int NUM_CLASSES = 7;
  localparam int CLASS_W     = 3;
  localparam int CHAN_W      = 8;

  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  localparam class_t CLS_ORANGE = 3'd0;
  localparam class_t CLS_YELLOW = 3'd1;
  localparam class_t CLS_GREEN  = 3'd2;
  localparam class_t CLS_BLUE   = 3'd3;
  localparam class_t CLS_PURPLE = 3'd4;
  localparam class_t CLS_PINK   = 3'd5;
  localparam class_t CLS_RED    = 3'd6;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam chan_t BLUE_FLOOR_RESET = 8'd100;

  localparam chan_t CLASS_LOWER [NUM_CLASSES] = '{
    8'd1, 8'd21, 8'd61, 8'd91, 8'd121, 8'd161, 8'd169
  };
  localparam chan_t CLASS_UPPER [NUM_CLASSES] = '{
    8'd20, 8'd30, 8'd90, 8'd120, 8'd160, 8'd168, 8'd180
  };

  typedef struct packed {
    chan_t hue_min;
    chan_t hue_max;
    chan_t sat_min;
    chan_t sat_max;
    chan_t val_min;
    chan_t val_max;
  } bounds_t;

  typedef struct packed {
    logic   hit;
    class_t cls;
  } lookup_t;

  // The ranges do not overlap, so at most one compare pair fires.
  function automatic lookup_t class_lookup(input chan_t hue);
    lookup_t res;
    res = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (hue >= CLASS_LOWER[k] && hue <= CLASS_UPPER[k]) begin
        res.hit = 1'b1;
        res.cls = class_t'(k);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hcmt_pixel_if.sv =====
// ----------------------------------------------------------------------------
// Hue class min/max tracker: pixel channel
// Valid/ready channel that carries one pixel or clear word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcmt_pixel_if;
  logic               valid;
  logic               ready;
  logic               kind;
  hcmt_pkg::chan_t    hue;
  hcmt_pkg::chan_t    saturation;
  hcmt_pkg::chan_t    brightness;

  modport source (output valid, output kind, output hue, output saturation,
                  output brightness, input ready);
  modport sink   (input valid, input kind, input hue, input saturation,
                  input brightness, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hcmt_result_if.sv =====
// ----------------------------------------------------------------------------
// Hue class min/max tracker: result channel
// Valid/ready channel that carries the class and its updated bounds.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcmt_result_if;
  logic               valid;
  logic               ready;
  logic               matched;
  hcmt_pkg::class_t   color_class;
  hcmt_pkg::chan_t    hue_min;
  hcmt_pkg::chan_t    hue_max;
  hcmt_pkg::chan_t    sat_min;
  hcmt_pkg::chan_t    sat_max;
  hcmt_pkg::chan_t    val_min;
  hcmt_pkg::chan_t    val_max;

  modport source (output valid, output matched, output color_class,
                  output hue_min, output hue_max, output sat_min, output sat_max,
                  output val_min, output val_max, input ready);
  modport sink   (input valid, input matched, input color_class,
                  input hue_min, input hue_max, input sat_min, input sat_max,
                  input val_min, input val_max, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hue_class_minmax_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Hue class min/max tracker
// Sorts HSV pixels into seven hue classes and tracks per-class channel bounds.
// ----------------------------------------------------------------------------
// Takes one word per clock while the result channel takes results, and returns
// one result word for each. When a word is accepted its class is looked up and
// the class entry is read from the bounds memory; in the update stage the entry is
// widened (or set, for the first pixel of a class) and written back, and the
// result is loaded into the output register. A pixel of the same class as the
// one just ahead of it takes the updated bounds from a bypass register, so no
// bubble is needed. The output register lets a new word in while a result
// waits. A clear word empties all classes at once through the per-class seen
// flags; bounds memory contents of an empty class are never used.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hue_class_minmax_tracker_unit_macros.svh"

module hue_class_minmax_tracker_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            blue_floor_we,
  input  wire hcmt_pkg::chan_t blue_floor_wdata,
  hcmt_pixel_if.sink           pixel,
  hcmt_result_if.source        result
);

  hcmt_pkg::chan_t    blue_floor;

  hcmt_pkg::bounds_t  mem [hcmt_pkg::NUM_CLASSES];
  hcmt_pkg::bounds_t  rdata;
  hcmt_pkg::bounds_t  byp_data;
  logic               byp;

  logic [hcmt_pkg::NUM_CLASSES-1:0] seen;

  // Update stage
  logic               s1_valid;
  logic               s1_clear;
  logic               s1_matched;
  hcmt_pkg::class_t   s1_cls;
  hcmt_pkg::chan_t    s1_h;
  hcmt_pkg::chan_t    s1_s;
  hcmt_pkg::chan_t    s1_v;

  // Output register
  logic               out_valid;
  logic               out_matched;
  hcmt_pkg::class_t   out_cls;
  hcmt_pkg::bounds_t  out_b;

  logic               in_acc;
  logic               s1_adv;
  logic               wr_en;
  hcmt_pkg::lookup_t  lk;
  hcmt_pkg::chan_t    in_s;
  hcmt_pkg::chan_t    in_v;
  hcmt_pkg::bounds_t  cur;
  hcmt_pkg::bounds_t  upd;

  logic               bounds_ordered;
  logic               core_idle;

  assign s1_adv      = s1_valid && (!out_valid || result.ready);
  assign pixel.ready = !s1_valid || s1_adv;
  assign in_acc      = pixel.valid && pixel.ready;
  assign wr_en       = s1_adv && s1_matched;

  always_comb begin
    lk   = hcmt_pkg::class_lookup(pixel.hue);
    in_s = pixel.saturation;
    in_v = pixel.brightness;
    if (lk.hit && lk.cls == hcmt_pkg::CLS_BLUE) begin
      if (in_s < blue_floor) in_s = blue_floor;
      if (in_v < blue_floor) in_v = blue_floor;
    end
  end

  always_comb begin
    cur = byp ? byp_data : rdata;
    if (!seen[s1_cls]) begin
      upd = '{s1_h, s1_h, s1_s, s1_s, s1_v, s1_v};
    end else begin
      upd         = cur;
      if (s1_h < cur.hue_min) upd.hue_min = s1_h;
      if (s1_h > cur.hue_max) upd.hue_max = s1_h;
      if (s1_s < cur.sat_min) upd.sat_min = s1_s;
      if (s1_s > cur.sat_max) upd.sat_max = s1_s;
      if (s1_v < cur.val_min) upd.val_min = s1_v;
      if (s1_v > cur.val_max) upd.val_max = s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blue_floor <= hcmt_pkg::BLUE_FLOOR_RESET;
    end else if (blue_floor_we) begin
      blue_floor <= blue_floor_wdata;
    end
  end

  // Bounds memory: the read returns the old entry when the same entry is
  // written on the same edge, which the bypass register covers.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_cls] <= upd;
    end
    if (in_acc) begin
      rdata <= mem[lk.cls];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_data <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (in_acc) begin
      byp <= wr_en && (s1_cls == lk.cls);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (s1_adv && s1_clear) begin
      seen <= '0;
    end else if (wr_en) begin
      seen[s1_cls] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_clear   <= (pixel.kind == hcmt_pkg::KIND_CLEAR);
      s1_matched <= (pixel.kind == hcmt_pkg::KIND_PIXEL) && lk.hit;
      s1_cls     <= lk.cls;
      s1_h       <= pixel.hue;
      s1_s       <= in_s;
      s1_v       <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_matched <= s1_matched;
      out_cls     <= s1_matched ? s1_cls : hcmt_pkg::CLS_ORANGE;
      out_b       <= s1_matched ? upd : '0;
    end
  end

  assign result.valid       = out_valid;
  assign result.matched     = out_matched;
  assign result.color_class = out_cls;
  assign result.hue_min     = out_b.hue_min;
  assign result.hue_max     = out_b.hue_max;
  assign result.sat_min     = out_b.sat_min;
  assign result.sat_max     = out_b.sat_max;
  assign result.val_min     = out_b.val_min;
  assign result.val_max     = out_b.val_max;

  assign bounds_ordered = (out_b.hue_min <= out_b.hue_max) &&
                          (out_b.sat_min <= out_b.sat_max) &&
                          (out_b.val_min <= out_b.val_max);
  assign core_idle      = (seen == '0) && !s1_valid && !out_valid;

  `HCMT_ASSERT(a_bounds_ordered, out_valid && out_matched |-> bounds_ordered, "bounds out of order")
  `HCMT_ASSERT(a_clear_empties, s1_adv && s1_clear |=> seen == '0, "clear left a class seen")
  `HCMT_ASSERT_ALWAYS(a_reset_state, rst |=> core_idle, "state not cleared by reset")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Hue class min/max tracker testbench
// Sends pixel and clear words, predicts the class and its bounds for each
// word, and checks every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic              matched;
    hcmt_pkg::class_t  color_class;
    hcmt_pkg::bounds_t bnd;
  } class_report_t;

  logic            clk;
  logic            rst;
  logic            blue_floor_we;
  hcmt_pkg::chan_t blue_floor_wdata;

  hcmt_pixel_if  pix ();
  hcmt_result_if res ();

  hue_class_minmax_tracker_unit dut (
    .clk              (clk),
    .rst              (rst),
    .blue_floor_we    (blue_floor_we),
    .blue_floor_wdata (blue_floor_wdata),
    .pixel            (pix),
    .result           (res)
  );

  // Predicted state of the tracker.
  hcmt_pkg::bounds_t class_mem [hcmt_pkg::NUM_CLASSES];
  bit                class_used [hcmt_pkg::NUM_CLASSES];
  hcmt_pkg::chan_t   floor_q = hcmt_pkg::BLUE_FLOOR_RESET;

  class_report_t pending_reports [$];
  class_report_t want;
  int            errors = 0;
  int            quiet = 0;
  bit            gap_on = 1'b1;
  bit            stall_on = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic class_report_t track_pixel(logic kind, hcmt_pkg::chan_t h,
                                                hcmt_pkg::chan_t s, hcmt_pkg::chan_t v);
    class_report_t     rep;
    hcmt_pkg::class_t  cls;
    bit                hit;
    hcmt_pkg::bounds_t b;
    rep = '0;
    hit = 1'b1;
    cls = hcmt_pkg::CLS_ORANGE;
    if (kind == hcmt_pkg::KIND_CLEAR) begin
      for (int k = 0; k < hcmt_pkg::NUM_CLASSES; k++) begin
        class_used[k] = 1'b0;
        class_mem[k] = '0;
      end
      return rep;
    end
    if (h >= 1 && h <= 20) cls = hcmt_pkg::CLS_ORANGE;
    else if (h >= 21 && h <= 30) cls = hcmt_pkg::CLS_YELLOW;
    else if (h >= 61 && h <= 90) cls = hcmt_pkg::CLS_GREEN;
    else if (h >= 91 && h <= 120) cls = hcmt_pkg::CLS_BLUE;
    else if (h >= 121 && h <= 160) cls = hcmt_pkg::CLS_PURPLE;
    else if (h >= 161 && h <= 168) cls = hcmt_pkg::CLS_PINK;
    else if (h >= 169 && h <= 180) cls = hcmt_pkg::CLS_RED;
    else hit = 1'b0;
    if (!hit) return rep;
    if (cls == hcmt_pkg::CLS_BLUE) begin
      if (s < floor_q) s = floor_q;
      if (v < floor_q) v = floor_q;
    end
    b = class_mem[cls];
    if (!class_used[cls]) begin
      b = {h, h, s, s, v, v};
    end else begin
      if (h < b.hue_min) b.hue_min = h;
      if (h > b.hue_max) b.hue_max = h;
      if (s < b.sat_min) b.sat_min = s;
      if (s > b.sat_max) b.sat_max = s;
      if (v < b.val_min) b.val_min = v;
      if (v > b.val_max) b.val_max = v;
    end
    class_mem[cls] = b;
    class_used[cls] = 1'b1;
    rep.matched = 1'b1;
    rep.color_class = cls;
    rep.bnd = b;
    return rep;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // Sends one word; valid stays high afterwards so back-to-back words need no bubble.
  task automatic send_word(logic kind, hcmt_pkg::chan_t h, hcmt_pkg::chan_t s,
                           hcmt_pkg::chan_t v);
    class_report_t rep;
    if (gap_on) begin
      while ($urandom_range(0, 99) < 30) begin
        pix.valid <= 1'b0;
        @(posedge clk);
      end
    end
    pix.valid      <= 1'b1;
    pix.kind       <= kind;
    pix.hue        <= h;
    pix.saturation <= s;
    pix.brightness <= v;
    do @(posedge clk); while (pix.ready !== 1'b1);
    rep = track_pixel(kind, h, s, v);
    pending_reports = {pending_reports, rep};
  endtask

  // Holds the sender off until every outstanding result word has come back.
  task automatic settle();
    pix.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_blue_floor(hcmt_pkg::chan_t f);
    settle();
    blue_floor_we    <= 1'b1;
    blue_floor_wdata <= f;
    @(posedge clk);
    blue_floor_we <= 1'b0;
    floor_q = f;
  endtask

  task automatic test_hue_edges();
    send_word(hcmt_pkg::KIND_PIXEL, 8'd0, 8'd255, 8'd255);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd1, 8'd0, 8'd255);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd20, 8'd255, 8'd0);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd21, 8'd128, 8'd128);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd30, 8'd0, 8'd0);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd31, 8'd10, 8'd10);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd60, 8'd10, 8'd10);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd61, 8'd255, 8'd255);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd90, 8'd1, 8'd254);
    // Blue below the floor is raised; the reset floor is in effect here.
    send_word(hcmt_pkg::KIND_PIXEL, 8'd91, 8'd0, 8'd0);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd120, 8'd255, 8'd50);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd121, 8'd85, 8'd170);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd160, 8'd170, 8'd85);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd161, 8'd0, 8'd255);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd168, 8'd255, 8'd0);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd169, 8'd64, 8'd192);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd180, 8'd192, 8'd64);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd181, 8'd255, 8'd255);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    send_word(hcmt_pkg::KIND_CLEAR, 8'd15, 8'd255, 8'd255);
    // The first pixel after a clear sets the bounds afresh.
    send_word(hcmt_pkg::KIND_PIXEL, 8'd15, 8'd7, 8'd9);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd100, 8'd150, 8'd99);
  endtask

  task automatic test_blue_floor();
    set_blue_floor(8'd0);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd100, 8'd0, 8'd0);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd110, 8'd255, 8'd3);
    set_blue_floor(8'd255);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd95, 8'd0, 8'd200);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd5, 8'd0, 8'd0);
    send_word(hcmt_pkg::KIND_CLEAR, 8'd0, 8'd0, 8'd0);
    send_word(hcmt_pkg::KIND_PIXEL, 8'd119, 8'd12, 8'd254);
  endtask

  task automatic test_random();
    hcmt_pkg::chan_t h;
    hcmt_pkg::chan_t s;
    hcmt_pkg::chan_t v;
    logic            kind;
    int              r;
    int              n;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_blue_floor(8'd1);
        1: set_blue_floor(8'd254);
        2: set_blue_floor(hcmt_pkg::chan_t'($urandom_range(0, 255)));
        3: set_blue_floor(hcmt_pkg::BLUE_FLOOR_RESET);
        4: set_blue_floor(8'd0);
        default: set_blue_floor(8'd255);
      endcase
      // One long phase runs with no random gaps or stalls on either side.
      gap_on   = (p != 2);
      stall_on = (p != 2);
      n = (p == 2) ? 300 : 210;
      for (int i = 0; i < n; i++) begin
        if (i == n / 2) settle();
        r = $urandom_range(0, 99);
        kind = hcmt_pkg::KIND_PIXEL;
        if (r < 2) begin
          kind = hcmt_pkg::KIND_CLEAR;
          h = hcmt_pkg::chan_t'($urandom_range(0, 255));
        end else if (r < 14) begin
          case ($urandom_range(0, 2))
            0: h = 8'd0;
            1: h = hcmt_pkg::chan_t'($urandom_range(31, 60));
            default: h = hcmt_pkg::chan_t'($urandom_range(181, 255));
          endcase
        end else begin
          case ($urandom_range(0, 6))
            0: h = hcmt_pkg::chan_t'($urandom_range(1, 20));
            1: h = hcmt_pkg::chan_t'($urandom_range(21, 30));
            2: h = hcmt_pkg::chan_t'($urandom_range(61, 90));
            3: h = hcmt_pkg::chan_t'($urandom_range(91, 120));
            4: h = hcmt_pkg::chan_t'($urandom_range(121, 160));
            5: h = hcmt_pkg::chan_t'($urandom_range(161, 168));
            default: h = hcmt_pkg::chan_t'($urandom_range(169, 180));
          endcase
        end
        s = ($urandom_range(0, 9) == 0) ? {8{1'($urandom_range(0, 1))}}
                                        : hcmt_pkg::chan_t'($urandom_range(0, 255));
        v = ($urandom_range(0, 9) == 0) ? {8{1'($urandom_range(0, 1))}}
                                        : hcmt_pkg::chan_t'($urandom_range(0, 255));
        send_word(kind, h, s, v);
      end
    end
    gap_on   = 1'b1;
    stall_on = 1'b1;
  endtask

  always @(posedge clk) begin
    res.ready <= !stall_on || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("matched", 8'(want.matched), 8'(res.matched));
        check_field("color_class", 8'(want.color_class), 8'(res.color_class));
        check_field("hue_min", want.bnd.hue_min, res.hue_min);
        check_field("hue_max", want.bnd.hue_max, res.hue_max);
        check_field("sat_min", want.bnd.sat_min, res.sat_min);
        check_field("sat_max", want.bnd.sat_max, res.sat_max);
        check_field("val_min", want.bnd.val_min, res.val_min);
        check_field("val_max", want.bnd.val_max, res.val_max);
      end
    end
  end

  // Ends a hung run: counts edges at which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("hue_class_minmax_tracker_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    rst              <= 1'b1;
    blue_floor_we    <= 1'b0;
    blue_floor_wdata <= '0;
    pix.valid        <= 1'b0;
    pix.kind         <= hcmt_pkg::KIND_PIXEL;
    pix.hue          <= '0;
    pix.saturation   <= '0;
    pix.brightness   <= '0;
    for (int k = 0; k < hcmt_pkg::NUM_CLASSES; k++) begin
      class_mem[k] = '0;
      class_used[k] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_hue_edges();
    test_blue_floor();
    test_random();
    settle();
    if (errors == 0) begin
      $display("hue_class_minmax_tracker_unit test passed");
    end else begin
      $display("hue_class_minmax_tracker_unit test failed");
    end
    $finish;
  end

endmodule
